// File: rtl/core/bis_pkg.sv
// Shared types, constants and helpers of the bilinear image sampler.
package bis_pkg;

	// Fixed-point format and field widths
	localparam int FRAC_BITS       = 8;
	localparam int SAMPLE_BITS     = 16;
	localparam int DEF_STORE_DEPTH = 65536;
	localparam int BOUND_W         = 20;
	localparam int COORD_W         = 12;
	localparam int ADDR_W          = 16;
	localparam int POS_W           = 22;
	localparam int SPAN_W          = COORD_W + 1;
	localparam int PROD_W          = COORD_W + SPAN_W;
	localparam int IDX_W           = 26;
	localparam int ONE_PIX         = 1 << FRAC_BITS;
	localparam int HALF_PIX        = 1 << (FRAC_BITS - 1);
	localparam int QUEUE_DEPTH     = 4;

	// Item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Result path codes
	localparam logic [1:0] PATH_EMPTY  = 2'd0;
	localparam logic [1:0] PATH_BORDER = 2'd1;
	localparam logic [1:0] PATH_BILIN  = 2'd2;
	localparam logic [1:0] PATH_CONST  = 2'd3;

	// Register map
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_BOUND_MIN_X  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOUND_MIN_Y  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_MIN_X = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_MIN_Y = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_MAX_X = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_MAX_Y = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_CONSTANT     = 3'd6;

	// Work for the store side
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ZERO = 2'd1,
		OP_ONE  = 2'd2,
		OP_FOUR = 2'd3
	} op_t;

	typedef struct packed {
		logic [BOUND_W-1:0] bound_min_x;
		logic [BOUND_W-1:0] bound_min_y;
		logic [COORD_W-1:0] window_min_x;
		logic [COORD_W-1:0] window_min_y;
		logic [COORD_W-1:0] window_max_x;
		logic [COORD_W-1:0] window_max_y;
		logic               constant_mode;
	} cfg_t;

	// One queued command: a store write, or a query with its base address
	typedef struct packed {
		op_t                    op;
		logic [1:0]             path;
		logic [IDX_W-1:0]       base;
		logic                   ok;
		logic [FRAC_BITS-1:0]   fx;
		logic [FRAC_BITS-1:0]   fy;
		logic [SAMPLE_BITS-1:0] value;
	} q_entry_t;

	function automatic logic signed [POS_W-1:0] sx_bound(input logic [BOUND_W-1:0] v);
		return POS_W'($signed(v));
	endfunction

	function automatic logic signed [POS_W-1:0] sx_coord(input logic [COORD_W-1:0] v);
		return POS_W'($signed(v));
	endfunction

endpackage

// File: rtl/core/bis_cfg.sv
// APB register block holding the sampler configuration.
module bis_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bis_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output bis_pkg::cfg_t               cfg
);
	import bis_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bound_min_x   <= '0;
			cfg_q.bound_min_y   <= '0;
			cfg_q.window_min_x  <= '0;
			cfg_q.window_min_y  <= '0;
			cfg_q.window_max_x  <= COORD_W'(255);
			cfg_q.window_max_y  <= COORD_W'(255);
			cfg_q.constant_mode <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_BOUND_MIN_X:  cfg_q.bound_min_x   <= pwdata[BOUND_W-1:0];
				REG_BOUND_MIN_Y:  cfg_q.bound_min_y   <= pwdata[BOUND_W-1:0];
				REG_WINDOW_MIN_X: cfg_q.window_min_x  <= pwdata[COORD_W-1:0];
				REG_WINDOW_MIN_Y: cfg_q.window_min_y  <= pwdata[COORD_W-1:0];
				REG_WINDOW_MAX_X: cfg_q.window_max_x  <= pwdata[COORD_W-1:0];
				REG_WINDOW_MAX_Y: cfg_q.window_max_y  <= pwdata[COORD_W-1:0];
				REG_CONSTANT:     cfg_q.constant_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux, signed fields sign extended
	always_comb begin
		unique case (reg_idx)
			REG_BOUND_MIN_X:  prdata = 32'($signed(cfg_q.bound_min_x));
			REG_BOUND_MIN_Y:  prdata = 32'($signed(cfg_q.bound_min_y));
			REG_WINDOW_MIN_X: prdata = 32'($signed(cfg_q.window_min_x));
			REG_WINDOW_MIN_Y: prdata = 32'($signed(cfg_q.window_min_y));
			REG_WINDOW_MAX_X: prdata = 32'($signed(cfg_q.window_max_x));
			REG_WINDOW_MAX_Y: prdata = 32'($signed(cfg_q.window_max_y));
			REG_CONSTANT:     prdata = 32'(cfg_q.constant_mode);
			default:          prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/bis_front.sv
// Front pipeline: takes items, classifies queries and computes store addresses.
module bis_front #(
	parameter int STORE_DEPTH = bis_pkg::DEF_STORE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bis_pkg::cfg_t                   cfg,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic                            kind,
	input  logic [bis_pkg::ADDR_W-1:0]      load_address,
	input  logic [bis_pkg::SAMPLE_BITS-1:0] load_value,
	input  logic signed [bis_pkg::BOUND_W-1:0] query_x,
	input  logic signed [bis_pkg::BOUND_W-1:0] query_y,
	output logic                            push,
	output bis_pkg::q_entry_t               push_entry,
	input  logic                            q_full,
	output logic [bis_pkg::SPAN_W-1:0]      row_len
);
	import bis_pkg::*;

	localparam int FB = FRAC_BITS;
	localparam logic signed [POS_W-1:0] HALF_P  = POS_W'(HALF_PIX);
	localparam logic signed [POS_W-1:0] ONE_LSB = POS_W'(1);
	localparam logic signed [POS_W-1:0] ONE_CRD = POS_W'(1);

	// Snap a coordinate within one LSB of the far edge to just inside it
	function automatic logic signed [POS_W-1:0] edge_fix(
		input logic signed [POS_W-1:0] p,
		input logic signed [POS_W-1:0] e
	);
		if (p >= e - ONE_LSB && p <= e + ONE_LSB)
			return e - ONE_LSB;
		return p;
	endfunction

	logic adv;
	logic load_ok;

	// stage registers
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                      load_s1;
	logic [IDX_W-1:0]          addr_s1, addr_s2, addr_s3, addr_s4;
	logic [SAMPLE_BITS-1:0]    val_s1, val_s2, val_s3, val_s4, val_s5;
	logic signed [POS_W-1:0]   pfx_s1, pfy_s1;
	op_t                       op_s2, op_s3, op_s4, op_s5;
	logic [1:0]                path_s2, path_s3, path_s4, path_s5;
	logic signed [POS_W-1:0]   px_s2, py_s2;
	logic [COORD_W-1:0]        rx_s3, ry_s3, rx_s4;
	logic                      ok_s3, ok_s4, ok_s5;
	logic [FB-1:0]             fx_s3, fy_s3, fx_s4, fy_s4, fx_s5, fy_s5;
	logic [PROD_W-1:0]         prod_s4;
	logic [IDX_W-1:0]          base_s5;

	// window geometry from the registers
	logic signed [POS_W-1:0] wmin_x, wmin_y, wmax_x, wmax_y;
	logic signed [POS_W-1:0] lo_x, lo_y, hi_x, hi_y, edge_x, edge_y;
	logic signed [POS_W-1:0] span_x, span_y;

	// stage 2 and 3 logic
	op_t                     op_c;
	logic [1:0]              path_c;
	logic signed [POS_W-1:0] px_c, py_c;
	logic                    empty_c, border_c;
	logic signed [POS_W-1:0] rel_x, rel_y;
	logic                    okx, oky;

	assign adv        = !v_s5 || !q_full;
	assign item_ready = adv;
	assign push       = v_s5 && !q_full;
	assign load_ok    = IDX_W'(load_address) < IDX_W'(STORE_DEPTH);

	assign wmin_x  = sx_coord(cfg.window_min_x);
	assign wmin_y  = sx_coord(cfg.window_min_y);
	assign wmax_x  = sx_coord(cfg.window_max_x);
	assign wmax_y  = sx_coord(cfg.window_max_y);
	assign lo_x    = (wmin_x <<< FB) + HALF_P;
	assign lo_y    = (wmin_y <<< FB) + HALF_P;
	assign hi_x    = (wmax_x <<< FB) + HALF_P;
	assign hi_y    = (wmax_y <<< FB) + HALF_P;
	assign edge_x  = (wmax_x + ONE_CRD) <<< FB;
	assign edge_y  = (wmax_y + ONE_CRD) <<< FB;
	assign span_x  = wmax_x - wmin_x + ONE_CRD;
	assign span_y  = wmax_y - wmin_y + ONE_CRD;
	assign row_len = span_x[SPAN_W-1:0];

	// Stage 1: position relative to the image bound
	always_ff @(posedge clk) begin
		if (adv) begin
			load_s1 <= (kind == KIND_LOAD);
			addr_s1 <= IDX_W'(load_address);
			val_s1  <= load_value;
			pfx_s1  <= POS_W'(query_x) - sx_bound(cfg.bound_min_x);
			pfy_s1  <= POS_W'(query_y) - sx_bound(cfg.bound_min_y);
		end
	end

	// Stage 2: choose path and the position to sample at
	always_comb begin
		empty_c  = (wmax_x < wmin_x) || (wmax_y < wmin_y);
		border_c = (pfx_s1 <= lo_x) || (pfy_s1 <= lo_y) ||
			(pfx_s1 >= hi_x) || (pfy_s1 >= hi_y);
		op_c   = OP_FOUR;
		path_c = PATH_BILIN;
		px_c   = pfx_s1 - HALF_P;
		py_c   = pfy_s1 - HALF_P;
		if (load_s1) begin
			op_c   = OP_LOAD;
			path_c = PATH_EMPTY;
		end else if (cfg.constant_mode) begin
			op_c   = OP_ONE;
			path_c = PATH_CONST;
		end else if (empty_c) begin
			op_c   = OP_ZERO;
			path_c = PATH_EMPTY;
		end else if (border_c) begin
			op_c   = OP_ONE;
			path_c = PATH_BORDER;
			px_c   = edge_fix(pfx_s1, edge_x);
			py_c   = edge_fix(pfy_s1, edge_y);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_c;
			path_s2 <= path_c;
			px_s2   <= px_c;
			py_s2   <= py_c;
			addr_s2 <= addr_s1;
			val_s2  <= val_s1;
		end
	end

	// Stage 3: integer pixel within the window, fraction, range check
	assign rel_x = (px_s2 >>> FB) - wmin_x;
	assign rel_y = (py_s2 >>> FB) - wmin_y;
	assign okx   = (rel_x >= 0) && (rel_x < span_x);
	assign oky   = (rel_y >= 0) && (rel_y < span_y);

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3   <= op_s2;
			path_s3 <= path_s2;
			addr_s3 <= addr_s2;
			val_s3  <= val_s2;
			ok_s3   <= (path_s2 == PATH_CONST) || (okx && oky);
			rx_s3   <= (path_s2 == PATH_CONST) ? '0 : rel_x[COORD_W-1:0];
			ry_s3   <= (path_s2 == PATH_CONST) ? '0 : rel_y[COORD_W-1:0];
			fx_s3   <= (op_s2 == OP_FOUR) ? px_s2[FB-1:0] : '0;
			fy_s3   <= (op_s2 == OP_FOUR) ? py_s2[FB-1:0] : '0;
		end
	end

	// Stage 4: row offset
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s4   <= op_s3;
			path_s4 <= path_s3;
			addr_s4 <= addr_s3;
			val_s4  <= val_s3;
			ok_s4   <= ok_s3;
			rx_s4   <= rx_s3;
			fx_s4   <= fx_s3;
			fy_s4   <= fy_s3;
			prod_s4 <= PROD_W'(ry_s3) * PROD_W'(row_len);
		end
	end

	// Stage 5: base address of the first neighbor, or the load address
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s5   <= op_s4;
			path_s5 <= path_s4;
			val_s5  <= val_s4;
			ok_s5   <= ok_s4;
			fx_s5   <= fx_s4;
			fy_s5   <= fy_s4;
			base_s5 <= (op_s4 == OP_LOAD) ? addr_s4 :
				IDX_W'(prod_s4) + IDX_W'(rx_s4);
		end
	end

	// Valid bits of the stages; out of range loads are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid && ((kind == KIND_QUERY) || load_ok);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		push_entry.op    = op_s5;
		push_entry.path  = path_s5;
		push_entry.base  = base_s5;
		push_entry.ok    = ok_s5;
		push_entry.fx    = fx_s5;
		push_entry.fy    = fy_s5;
		push_entry.value = val_s5;
	end

endmodule

// File: rtl/core/bis_queue.sv
// Small command FIFO between the front pipeline and the store side.
module bis_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bis_pkg::q_entry_t push_entry,
	input  logic              pop,
	output bis_pkg::q_entry_t head,
	output logic              full,
	output logic              empty
);
	import bis_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t          ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: rtl/core/bis_back.sv
// Store side: sample memory, neighbor fetch sequencer and bilinear mix pipeline.
module bis_back #(
	parameter int STORE_DEPTH = bis_pkg::DEF_STORE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  bis_pkg::q_entry_t               q_head,
	output logic                            q_pop,
	input  logic [bis_pkg::SPAN_W-1:0]      row_len,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [bis_pkg::SAMPLE_BITS-1:0] sample_value,
	output logic [1:0]                      path_taken
);
	import bis_pkg::*;

	localparam int FB    = FRAC_BITS;
	localparam int SB    = SAMPLE_BITS;
	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int P1_W  = SB + FB + 1;
	localparam int P2_W  = P1_W + FB + 1;
	localparam int SUM_W = P2_W + 1;
	localparam logic [FB:0] ONE_W = (FB + 1)'(ONE_PIX);

	// neighbor slots: a (x0,y0), b (x0+1,y0), c (x0,y0+1), d (x0+1,y0+1)
	localparam logic [1:0] SLOT_A = 2'd0;
	localparam logic [1:0] SLOT_B = 2'd1;
	localparam logic [1:0] SLOT_C = 2'd2;
	localparam logic [1:0] SLOT_D = 2'd3;

	typedef enum logic [1:0] {
		ISS_POP  = 2'b01,
		ISS_REST = 2'b10
	} iss_state_t;

	iss_state_t        state_q;
	logic [1:0]        cnt_q;
	q_entry_t          ent_q;

	logic [SB-1:0]     store_mem [STORE_DEPTH];
	logic [SB-1:0]     rd_q;

	// issue logic
	logic              adv;
	q_entry_t          cur;
	logic [1:0]        slot;
	logic [IDX_W-1:0]  off;
	logic [IDX_W-1:0]  addr;
	logic              in_store;
	logic              iss_go, wr_en, tok, rd_en;
	logic [AW-1:0]     mem_addr;

	// fetch stage
	logic              v_s1, last_s1, four_s1, rd_s1;
	logic [1:0]        slot_s1, path_s1;
	logic [FB-1:0]     fx_s1, fy_s1;
	logic [SB-1:0]     d_now;
	logic [SB-1:0]     sa_q, sb_q, sc_q;

	// mix stages
	logic [SB-1:0]     a_in, b_in, c_in, d_in;
	logic              v_s2, v_s3, v_s4;
	logic [1:0]        path_s2, path_s3, path_s4;
	logic [P1_W-1:0]   pa_s2, pb_s2, pc_s2, pd_s2;
	logic [FB-1:0]     fy_s2, fy_s3;
	logic [P1_W-1:0]   xe_s3, ye_s3;
	logic [P2_W-1:0]   t1_s4, t2_s4;
	logic [SUM_W-1:0]  sum;

	logic              result_valid_q;
	logic [SB-1:0]     sample_value_q;
	logic [1:0]        path_taken_q;

	assign adv          = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign sample_value = sample_value_q;
	assign path_taken   = path_taken_q;

	// Pick the command and neighbor slot to issue this cycle
	always_comb begin
		cur  = q_head;
		slot = SLOT_A;
		if (state_q == ISS_REST) begin
			cur  = ent_q;
			slot = cnt_q;
		end
		unique case (slot)
			SLOT_A:  off = '0;
			SLOT_B:  off = IDX_W'(1);
			SLOT_C:  off = IDX_W'(row_len);
			SLOT_D:  off = IDX_W'(row_len) + IDX_W'(1);
			default: off = '0;
		endcase
		addr     = cur.base + off;
		in_store = addr < IDX_W'(STORE_DEPTH);
		iss_go   = adv && ((state_q == ISS_REST) || !q_empty);
		wr_en    = iss_go && (state_q == ISS_POP) && (cur.op == OP_LOAD);
		tok      = iss_go && (cur.op != OP_LOAD);
		rd_en    = tok && cur.ok && in_store &&
			((cur.op == OP_ONE) || (cur.op == OP_FOUR));
		mem_addr = addr[AW-1:0];
	end

	assign q_pop = adv && (state_q == ISS_POP) && !q_empty;

	// Sequencer: a bilinear command holds the port for four reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ISS_POP;
			cnt_q   <= SLOT_A;
		end else if (iss_go) begin
			unique case (state_q)
				ISS_POP: begin
					if (cur.op == OP_FOUR) begin
						state_q <= ISS_REST;
						cnt_q   <= SLOT_B;
					end
				end
				ISS_REST: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SLOT_D)
						state_q <= ISS_POP;
				end
				default: state_q <= ISS_POP;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			ent_q <= q_head;
	end

	// Single-port sample store
	always_ff @(posedge clk) begin
		if (wr_en)
			store_mem[mem_addr] <= cur.value;
		if (rd_en)
			rd_q <= store_mem[mem_addr];
	end

	// Fetch stage control
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= (cur.op != OP_FOUR) || (slot == SLOT_D);
			four_s1 <= (cur.op == OP_FOUR);
			rd_s1   <= rd_en;
			slot_s1 <= slot;
			path_s1 <= cur.path;
			fx_s1   <= cur.fx;
			fy_s1   <= cur.fy;
		end
	end

	// Samples outside the window or the store read as zero
	assign d_now = rd_s1 ? rd_q : '0;

	// Collect the first three neighbors
	always_ff @(posedge clk) begin
		if (adv && v_s1 && four_s1 && !last_s1) begin
			case (slot_s1)
				SLOT_A:  sa_q <= d_now;
				SLOT_B:  sb_q <= d_now;
				default: sc_q <= d_now;
			endcase
		end
	end

	// Single reads go through the mix with zero weights on the others
	always_comb begin
		a_in = four_s1 ? sa_q : d_now;
		b_in = four_s1 ? sb_q : '0;
		c_in = four_s1 ? sc_q : '0;
		d_in = four_s1 ? d_now : '0;
	end

	// Mix stage 1: weighted samples along x
	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s2   <= P1_W'(a_in) * P1_W'(ONE_W - {1'b0, fx_s1});
			pb_s2   <= P1_W'(b_in) * P1_W'(fx_s1);
			pc_s2   <= P1_W'(c_in) * P1_W'(ONE_W - {1'b0, fx_s1});
			pd_s2   <= P1_W'(d_in) * P1_W'(fx_s1);
			fy_s2   <= fy_s1;
			path_s2 <= path_s1;
		end
	end

	// Mix stage 2: row sums
	always_ff @(posedge clk) begin
		if (adv) begin
			xe_s3   <= pa_s2 + pb_s2;
			ye_s3   <= pc_s2 + pd_s2;
			fy_s3   <= fy_s2;
			path_s3 <= path_s2;
		end
	end

	// Mix stage 3: weighted rows along y
	always_ff @(posedge clk) begin
		if (adv) begin
			t1_s4   <= P2_W'(xe_s3) * P2_W'(ONE_W - {1'b0, fy_s3});
			t2_s4   <= P2_W'(ye_s3) * P2_W'(fy_s3);
			path_s4 <= path_s3;
		end
	end

	// Output register, floor by dropping both fractions
	assign sum = SUM_W'(t1_s4) + SUM_W'(t2_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_value_q <= SB'(sum >> (2 * FB));
			path_taken_q   <= path_s4;
		end
	end

	// Transaction valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1           <= tok;
			v_s2           <= v_s1 && last_s1;
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			result_valid_q <= v_s4;
		end
	end

endmodule

// File: rtl/core/bilinear_image_sampler.sv
// A query result passes the front stages, the command queue, the store read, the fetch
// stage, the mix stages and the output register. Loads and single-read queries go one per
// cycle unless stalled; a bilinear query holds the single-port store for four neighbor reads.
// A 4-entry command queue lets the front pipeline keep taking items while the store is busy.
// Reset clears control state and sets the registers to their defaults; the sample store
// is not cleared and holds undefined data until written.
module bilinear_image_sampler #(
	parameter int STORE_DEPTH = bis_pkg::DEF_STORE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bis_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic                               kind,
	input  logic [bis_pkg::ADDR_W-1:0]         load_address,
	input  logic [bis_pkg::SAMPLE_BITS-1:0]    load_value,
	input  logic signed [bis_pkg::BOUND_W-1:0] query_x,
	input  logic signed [bis_pkg::BOUND_W-1:0] query_y,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [bis_pkg::SAMPLE_BITS-1:0]    sample_value,
	output logic [1:0]                         path_taken
);
	import bis_pkg::*;

	cfg_t              cfg;
	logic              push, pop, q_full, q_empty;
	q_entry_t          push_entry, q_head;
	logic [SPAN_W-1:0] row_len;

	// Configuration registers
	bis_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Classification and address generation
	bis_front #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.load_address (load_address),
		.load_value   (load_value),
		.query_x      (query_x),
		.query_y      (query_y),
		.push         (push),
		.push_entry   (push_entry),
		.q_full       (q_full),
		.row_len      (row_len)
	);

	// Command queue
	bis_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	// Store access and interpolation
	bis_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (pop),
		.row_len      (row_len),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sample_value (sample_value),
		.path_taken   (path_taken)
	);

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the bilinear image sampler: predictor, driver, monitor, phases.
module tb_top;
	import bis_pkg::*;

	localparam int DEPTH        = DEF_STORE_DEPTH;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;

	typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

	typedef struct {
		logic                   kind;
		logic [ADDR_W-1:0]      addr;
		logic [SAMPLE_BITS-1:0] value;
		logic [BOUND_W-1:0]     qx;
		logic [BOUND_W-1:0]     qy;
	} sampler_txn_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [1:0]             path;
	} sample_result_t;

	typedef struct {
		longint bmx, bmy;
		longint wminx, wminy, wmaxx, wmaxy;
		bit     cmode;
	} sampler_cfg_t;

	// Clock, reset, configuration port
	logic                   clk     = 1'b0;
	logic                   arst_n  = 1'b0;
	logic                   psel    = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite  = 1'b0;
	logic [PADDR_W-1:0]     paddr   = '0;
	logic [31:0]            pwdata  = '0;
	logic [31:0]            prdata;
	logic                   pready;

	// Item and result channels
	logic                   item_valid   = 1'b0;
	logic                   item_ready;
	logic                   kind         = KIND_LOAD;
	logic [ADDR_W-1:0]      load_address = '0;
	logic [SAMPLE_BITS-1:0] load_value   = '0;
	logic signed [BOUND_W-1:0] query_x   = '0;
	logic signed [BOUND_W-1:0] query_y   = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic [SAMPLE_BITS-1:0] sample_value;
	logic [1:0]             path_taken;

	// Testbench state
	sampler_txn_t           pending_q[$];
	sample_result_t         expected_samples[$];
	logic [SAMPLE_BITS-1:0] store_img [0:DEPTH-1];
	bit                     loaded_map [0:DEPTH-1];
	sampler_cfg_t           cur_cfg;
	int                     send_gap_pct   = 0;
	int                     recv_stall_pct = 0;
	int                     mismatch_count = 0;
	int                     cycle_count    = 0;
	int                     gen_count      = 0;
	bit                     hold_req       = 1'b0;
	bit                     hold_done      = 1'b0;
	int                     hold_left      = 0;

	bilinear_image_sampler u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.load_address (load_address),
		.load_value   (load_value),
		.query_x      (query_x),
		.query_y      (query_y),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sample_value (sample_value),
		.path_taken   (path_taken)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Store lookup; pixels outside the window or past the store read as zero
	function automatic longint read_pixel(input longint px, input longint py);
		longint w, h, idx;
		w = cur_cfg.wmaxx - cur_cfg.wminx + 1;
		h = cur_cfg.wmaxy - cur_cfg.wminy + 1;
		if (px < 0 || py < 0 || px >= w || py >= h)
			return 0;
		idx = py * w + px;
		if (idx >= DEPTH)
			return 0;
		return longint'(store_img[int'(idx)]);
	endfunction

	// Positions within one LSB of the far edge are pulled just inside it
	function automatic longint clamp_far_edge(input longint p, input longint wmax);
		longint e;
		e = (wmax + 1) * ONE_PIX;
		if (p >= e - 1 && p <= e + 1)
			return e - 1;
		return p;
	endfunction

	// Predict what one accepted transaction does: store write or one sampled result
	function automatic void predict_sample(input sampler_txn_t t);
		longint pfx, pfy, x0, y0, fx, fy, acc;
		sample_result_t r;
		if (t.kind == KIND_LOAD) begin
			store_img[t.addr] = t.value;
			return;
		end
		pfx = longint'($signed(t.qx)) - cur_cfg.bmx;
		pfy = longint'($signed(t.qy)) - cur_cfg.bmy;
		if (cur_cfg.cmode) begin
			r.sample = store_img[0];
			r.path   = PATH_CONST;
		end else if (cur_cfg.wmaxx < cur_cfg.wminx || cur_cfg.wmaxy < cur_cfg.wminy) begin
			r.sample = '0;
			r.path   = PATH_EMPTY;
		end else if (pfx <= cur_cfg.wminx * ONE_PIX + HALF_PIX ||
				pfy <= cur_cfg.wminy * ONE_PIX + HALF_PIX ||
				pfx >= cur_cfg.wmaxx * ONE_PIX + HALF_PIX ||
				pfy >= cur_cfg.wmaxy * ONE_PIX + HALF_PIX) begin
			pfx = clamp_far_edge(pfx, cur_cfg.wmaxx);
			pfy = clamp_far_edge(pfy, cur_cfg.wmaxy);
			r.sample = SAMPLE_BITS'(read_pixel((pfx >>> FRAC_BITS) - cur_cfg.wminx,
				(pfy >>> FRAC_BITS) - cur_cfg.wminy));
			r.path   = PATH_BORDER;
		end else begin
			// shift back half a pixel, weights are the fraction bits; floor of exact sum
			pfx = pfx - HALF_PIX;
			pfy = pfy - HALF_PIX;
			x0  = pfx >>> FRAC_BITS;
			y0  = pfy >>> FRAC_BITS;
			fx  = pfx - x0 * ONE_PIX;
			fy  = pfy - y0 * ONE_PIX;
			x0  = x0 - cur_cfg.wminx;
			y0  = y0 - cur_cfg.wminy;
			acc = read_pixel(x0, y0) * (ONE_PIX - fx) * (ONE_PIX - fy)
				+ read_pixel(x0 + 1, y0) * fx * (ONE_PIX - fy)
				+ read_pixel(x0, y0 + 1) * (ONE_PIX - fx) * fy
				+ read_pixel(x0 + 1, y0 + 1) * fx * fy;
			r.sample = SAMPLE_BITS'(acc >>> (2 * FRAC_BITS));
			r.path   = PATH_BILIN;
		end
		expected_samples.insert(expected_samples.size(), r);
	endfunction

	// Driver: presents queued items, predicts on each accepted transaction
	always @(posedge clk or negedge arst_n) begin : item_driver
		sampler_txn_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				nxt.kind  = kind;
				nxt.addr  = load_address;
				nxt.value = load_value;
				nxt.qx    = query_x;
				nxt.qy    = query_y;
				predict_sample(nxt);
			end
			if (!item_valid || item_ready) begin
				if (pending_q.size() != 0 && int'($urandom_range(99)) >= send_gap_pct) begin
					nxt = pending_q.pop_front();
					item_valid   <= 1'b1;
					kind         <= nxt.kind;
					load_address <= nxt.addr;
					load_value   <= nxt.value;
					query_x      <= nxt.qx;
					query_y      <= nxt.qy;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold, counted on its own
	always @(posedge clk or negedge arst_n) begin : long_hold
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each result transaction, drives result_ready with stalls and the long hold
	always @(posedge clk or negedge arst_n) begin : result_monitor
		sample_result_t exp_r;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_samples.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("unexpected result: sample_value %0d path_taken %0d",
							sample_value, path_taken);
					mismatch_count++;
				end else begin
					exp_r = expected_samples.pop_front();
					if (sample_value !== exp_r.sample || path_taken !== exp_r.path) begin
						if (mismatch_count < MAX_REPORTS)
							$display({"mismatch: sample_value exp %0d got %0d, ",
								"path_taken exp %0d got %0d"},
								exp_r.sample, sample_value, exp_r.path, path_taken);
						mismatch_count++;
					end
				end
			end
			if (hold_left > 0)
				result_ready <= 1'b0;
			else
				result_ready <= int'($urandom_range(99)) >= recv_stall_pct;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input longint val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_config(input sampler_cfg_t c);
		write_reg(REG_BOUND_MIN_X, c.bmx);
		write_reg(REG_BOUND_MIN_Y, c.bmy);
		write_reg(REG_WINDOW_MIN_X, c.wminx);
		write_reg(REG_WINDOW_MIN_Y, c.wminy);
		write_reg(REG_WINDOW_MAX_X, c.wmaxx);
		write_reg(REG_WINDOW_MAX_Y, c.wmaxy);
		write_reg(REG_CONSTANT, longint'(c.cmode));
		cur_cfg = c;
	endtask

	function automatic sampler_cfg_t make_cfg(input longint bx, input longint by,
			input longint wx0, input longint wy0, input longint wx1, input longint wy1,
			input bit cm);
		sampler_cfg_t c;
		c.bmx   = bx;
		c.bmy   = by;
		c.wminx = wx0;
		c.wminy = wy0;
		c.wmaxx = wx1;
		c.wmaxy = wy1;
		c.cmode = cm;
		return c;
	endfunction

	// Small random window around the origin, random bound
	function automatic sampler_cfg_t rand_cfg();
		longint wx0, wy0;
		wx0 = longint'($urandom_range(40)) - 20;
		wy0 = longint'($urandom_range(40)) - 20;
		return make_cfg(longint'($urandom_range(1048575)) - 524288,
			longint'($urandom_range(1048575)) - 524288,
			wx0, wy0, wx0 + longint'($urandom_range(15)), wy0 + longint'($urandom_range(15)),
			1'b0);
	endfunction

	// Position along one axis relative to the bound: interior, far edge, border line, anywhere
	function automatic longint pick_axis(input longint wmin, input longint wmax);
		int unsigned r;
		longint span;
		r    = $urandom_range(99);
		span = (wmax > wmin) ? wmax - wmin : 0;
		if (r < 45)
			return (wmin - 1 + longint'($urandom_range(int'(span) + 2))) * ONE_PIX
				+ longint'($urandom_range(ONE_PIX - 1));
		if (r < 60)
			return (wmax + 1) * ONE_PIX + longint'($urandom_range(4)) - 2;
		if (r < 75)
			return ((($urandom_range(1) == 0) ? wmin : wmax) * ONE_PIX) + HALF_PIX
				+ longint'($urandom_range(2)) - 1;
		return longint'($urandom_range(2097151)) - 1048576;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return SAMPLE_BITS'($urandom);
	endfunction

	task automatic push_load(input logic [ADDR_W-1:0] addr, input logic [SAMPLE_BITS-1:0] val);
		sampler_txn_t t;
		t.kind  = KIND_LOAD;
		t.addr  = addr;
		t.value = val;
		t.qx    = BOUND_W'($urandom);
		t.qy    = BOUND_W'($urandom);
		loaded_map[addr] = 1'b1;
		pending_q.insert(pending_q.size(), t);
		gen_count++;
	endtask

	// Load a store entry first if nothing has been queued for it yet
	task automatic need_index(input longint idx);
		if (idx < DEPTH && !loaded_map[int'(idx)])
			push_load(ADDR_W'(idx), pick_sample());
	endtask

	task automatic need_pixel(input longint px, input longint py);
		longint w, h;
		w = cur_cfg.wmaxx - cur_cfg.wminx + 1;
		h = cur_cfg.wmaxy - cur_cfg.wminy + 1;
		if (px >= 0 && py >= 0 && px < w && py < h)
			need_index(py * w + px);
	endtask

	// Every sample that a query at this position reads gets written before the query
	task automatic prep_query(input longint pfx, input longint pfy);
		longint x0, y0;
		if (cur_cfg.cmode) begin
			need_index(0);
		end else if (cur_cfg.wmaxx >= cur_cfg.wminx && cur_cfg.wmaxy >= cur_cfg.wminy) begin
			if (pfx <= cur_cfg.wminx * ONE_PIX + HALF_PIX ||
					pfy <= cur_cfg.wminy * ONE_PIX + HALF_PIX ||
					pfx >= cur_cfg.wmaxx * ONE_PIX + HALF_PIX ||
					pfy >= cur_cfg.wmaxy * ONE_PIX + HALF_PIX) begin
				x0 = (clamp_far_edge(pfx, cur_cfg.wmaxx) >>> FRAC_BITS) - cur_cfg.wminx;
				y0 = (clamp_far_edge(pfy, cur_cfg.wmaxy) >>> FRAC_BITS) - cur_cfg.wminy;
				need_pixel(x0, y0);
			end else begin
				x0 = ((pfx - HALF_PIX) >>> FRAC_BITS) - cur_cfg.wminx;
				y0 = ((pfy - HALF_PIX) >>> FRAC_BITS) - cur_cfg.wminy;
				need_pixel(x0, y0);
				need_pixel(x0 + 1, y0);
				need_pixel(x0, y0 + 1);
				need_pixel(x0 + 1, y0 + 1);
			end
		end
	endtask

	// Position given relative to the current bound; wraps to the port width
	task automatic push_query(input longint pfx, input longint pfy);
		sampler_txn_t t;
		t.kind  = KIND_QUERY;
		t.addr  = ADDR_W'($urandom);
		t.value = SAMPLE_BITS'($urandom);
		t.qx    = BOUND_W'(pfx + cur_cfg.bmx);
		t.qy    = BOUND_W'(pfy + cur_cfg.bmy);
		prep_query(longint'($signed(t.qx)) - cur_cfg.bmx,
			longint'($signed(t.qy)) - cur_cfg.bmy);
		pending_q.insert(pending_q.size(), t);
		gen_count++;
	endtask

	task automatic gen_items(input int n);
		int unsigned r;
		int stop;
		stop = gen_count + n;
		while (gen_count < stop) begin
			if ($urandom_range(99) < 25) begin
				r = $urandom_range(99);
				if (r < 10)
					push_load('0, pick_sample());
				else if (r < 50)
					push_load(ADDR_W'($urandom_range(255)), pick_sample());
				else
					push_load(ADDR_W'($urandom), pick_sample());
			end else begin
				push_query(pick_axis(cur_cfg.wminx, cur_cfg.wmaxx),
					pick_axis(cur_cfg.wminy, cur_cfg.wmaxy));
			end
		end
	endtask

	// Poll on the falling edge so driver updates of the same rising edge are visible
	task automatic wait_drained();
		while (pending_q.size() != 0 || item_valid || expected_samples.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input sampler_cfg_t c, input pace_t pace, input int n);
		wait_drained();
		apply_config(c);
		case (pace)
			PACE_FULL: begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			PACE_SEND_GAPS: begin
				send_gap_pct   = 59;
				recv_stall_pct = 0;
			end
			PACE_RECV_STALLS: begin
				send_gap_pct   = 0;
				recv_stall_pct = 59;
			end
			default: begin
				send_gap_pct   = 34;
				recv_stall_pct = 34;
			end
		endcase
		gen_items(n);
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// default geometry
		run_phase(make_cfg(0, 0, 0, 0, 255, 255, 1'b0), PACE_FULL, 0);

		// directed: full-scale neighbors, fraction extremes, border lines, far edge clamp
		push_load(16'd0, 16'hFFFF);
		push_load(16'd1, 16'hFFFF);
		push_load(16'd256, 16'hFFFF);
		push_load(16'd257, 16'hFFFF);
		push_load(16'd258, 16'h0000);
		push_load(16'hFFFF, 16'hFFFF);
		push_load(16'h5A5A, 16'h0000);
		push_query(129, 129);
		push_query(384, 384);
		push_query(383, 383);
		push_query(128, 200);
		push_query(65407, 65407);
		push_query(65408, 1000);
		push_query(65535, 65535);
		push_query(65536, 65536);
		push_query(65537, 65537);
		push_query(65538, 300);
		push_query(-524288, -524288);
		push_query(524287, 524287);
		push_query(-1, -1);
		push_query(0, 0);

		// directed: empty window, then constant mode with sample 0 rewritten in between
		run_phase(make_cfg(0, 0, 5, 0, 4, 255, 1'b0), PACE_FULL, 0);
		push_query(0, 0);
		push_query(524287, -524288);
		run_phase(make_cfg(0, 0, 0, 0, 255, 255, 1'b1), PACE_FULL, 0);
		push_query(300, 300);
		push_load(16'd0, 16'h0001);
		push_query(-524288, 524287);

		// random phases over several geometries and pacing modes
		run_phase(make_cfg(0, 0, 0, 0, 255, 255, 1'b0), PACE_FULL, 140);
		run_phase(make_cfg(1000, -3000, -4, -3, 9, 6, 1'b0), PACE_SEND_GAPS, 140);
		run_phase(make_cfg(-524288, 524287, -2048, -2048, 2047, -2040, 1'b0),
			PACE_RECV_STALLS, 140);
		hold_req = 1'b1;
		run_phase(make_cfg(524287, -524288, 2040, 2047, 2047, 2047, 1'b0), PACE_BOTH, 140);
		run_phase(make_cfg(0, 0, 5, 0, 4, 255, 1'b0), PACE_FULL, 60);
		run_phase(make_cfg(-777, 4321, -3, 2047, 3, -2048, 1'b0), PACE_BOTH, 40);
		run_phase(make_cfg(12345, -54321, -2, -2, 2, 2, 1'b1), PACE_SEND_GAPS, 80);
		run_phase(rand_cfg(), PACE_RECV_STALLS, 140);
		run_phase(rand_cfg(), PACE_BOTH, 140);
		run_phase(make_cfg(-256, 512, 3, 3, 3, 3, 1'b0), PACE_FULL, 80);

		wait_drained();
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
